// File: hw/rtl/zdf_pkg.sv
// ----------------------------------------------------------------------------
// zdf_pkg: shared types, constants and arithmetic helpers
// Holds the coefficient register map, the command bundle passed from the
// sequencer to the datapath, and the rounding and saturation functions.
// ----------------------------------------------------------------------------
`default_nettype none

package zdf_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SQUARED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CUBED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATE_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_NORM = 3'd5;

  // Reset values of the coefficients.
  localparam logic [15:0] RST_STAGE_GAIN    = 16'd4031;
  localparam logic [15:0] RST_GAIN_SQUARED  = 16'd248;
  localparam logic [15:0] RST_GAIN_CUBED    = 16'd15;
  localparam logic [16:0] RST_STATE_SCALE   = 17'd61505;
  localparam logic [18:0] RST_RESONANCE     = 19'd262144;
  localparam logic [16:0] RST_FEEDBACK_NORM = 17'd65532;

  // Datapath widths.
  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 32;
  localparam int OPA_W    = 33;  // state difference, sign included
  localparam int OPB_W    = 20;  // widest coefficient plus a zero sign bit
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int FRAC_W   = 16;
  localparam int RND_W    = PROD_W + 1 - FRAC_W;
  localparam int WIDE_W   = RND_W + 2;

  localparam int NSTAGES = 4;
  localparam int STG_W   = 2;

  typedef struct packed {
    logic [15:0] stage_gain;
    logic [15:0] gain_squared;
    logic [15:0] gain_cubed;
    logic [16:0] state_scale;
    logic [18:0] resonance_gain;
    logic [16:0] feedback_norm;
  } cfg_t;

  // Multiply operations issued by the sequencer.
  typedef enum logic [2:0] {
    OP_SCALE,   // z[i] * state_scale
    OP_FB0,     // s0 * G^3
    OP_FB1,     // s1 * G^2
    OP_FB2,     // s2 * G
    OP_RES,     // S * k
    OP_NORM,    // (x - ks) * feedback_norm
    OP_STAGE    // (lp - z[i]) * G
  } op_t;

  typedef struct packed {
    logic              load_x;
    logic              mul_en;
    logic              post_en;
    logic              load_out;
    op_t               op;
    logic [STG_W-1:0]  idx;
  } cmd_t;

  // Shift right by 16 with rounding half toward plus infinity.
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = {p[PROD_W-1], p} + (PROD_W+1)'(32768);
    return t[PROD_W:FRAC_W];
  endfunction

  // Clamp to the signed 32-bit state range.
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] a);
    logic hi_same;
    logic hi_zero;
    hi_zero = (a[WIDE_W-1:STATE_W-1] == '0);
    hi_same = hi_zero || (a[WIDE_W-1:STATE_W-1] == '1);
    if (hi_same) begin
      return a[STATE_W-1:0];
    end else if (a[WIDE_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  // Clamp a state value to the signed 24-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STATE_W-1:0] a);
    logic hi_same;
    hi_same = (a[STATE_W-1:SAMPLE_W-1] == '0) || (a[STATE_W-1:SAMPLE_W-1] == '1);
    if (hi_same) begin
      return a[SAMPLE_W-1:0];
    end else if (a[STATE_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/zdf_four_pole_ladder_filter.sv
// ----------------------------------------------------------------------------
// zdf_four_pole_ladder_filter: four-pole zero-delay-feedback ladder lowpass
// Fixed-point resonant lowpass with four trapezoidal one-pole stages and a
// resolved feedback loop. Coefficients are loaded by software.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                            Direction  Transaction
//   -------   --------------------------------   ---------  ----------------------
//   input     in_valid, in_ready, sample_in      in         one Q1.23 sample
//   output    out_valid, out_ready, sample_out   out        one Q1.23 lowpass sample
//   config    cfg_we, cfg_index, cfg_data        in         one coefficient write
//
// Each sample passes thirteen products through one shared multiplier,
// each taking a multiply step and a rounding/saturation step, followed
// by a step that loads the output register. A new input transaction is
// accepted only once that output step of the previous sample is done.
// A new sample is accepted while the previous result still waits in the
// output register; the filter only stalls at its output step when that
// register is still occupied.
// Synchronous reset clears the integrator states and handshake control and
// restores the default coefficients.
//
// Computation per sample, with all Q.16 products rounded half up:
//   s_i = sat(z_i * scale), S = sat(G^3 s0 + G^2 s1 + G s2 + s3),
//   u = sat((x - sat(k S)) * norm), then four stages of
//   v = (lp - z_i) * G, lp = sat(v + z_i), z_i = sat(lp + v).
// ----------------------------------------------------------------------------
`default_nettype none

module zdf_four_pole_ladder_filter
  import zdf_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [SAMPLE_W-1:0]  sample_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]       sample_out,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  cfg_t cfg;
  cmd_t cmd;

  // Coefficient registers; the user must write them only while the filter is idle (not enforced here).
  zdf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The sequencer owns both handshakes and issues one command per cycle.
  zdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the multiplier, the integrator states and the
  // output sample register.
  zdf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire

// File: hw/rtl/zdf_cfg.sv
// ----------------------------------------------------------------------------
// zdf_cfg: coefficient register file
// Six coefficient registers written through a simple write port.
// ----------------------------------------------------------------------------
`default_nettype none

module zdf_cfg
  import zdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stage_gain     <= RST_STAGE_GAIN;
      cfg.gain_squared   <= RST_GAIN_SQUARED;
      cfg.gain_cubed     <= RST_GAIN_CUBED;
      cfg.state_scale    <= RST_STATE_SCALE;
      cfg.resonance_gain <= RST_RESONANCE;
      cfg.feedback_norm  <= RST_FEEDBACK_NORM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STAGE_GAIN:    cfg.stage_gain     <= cfg_data[15:0];
        REG_GAIN_SQUARED:  cfg.gain_squared   <= cfg_data[15:0];
        REG_GAIN_CUBED:    cfg.gain_cubed     <= cfg_data[15:0];
        REG_STATE_SCALE:   cfg.state_scale    <= cfg_data[16:0];
        REG_RESONANCE:     cfg.resonance_gain <= cfg_data[18:0];
        REG_FEEDBACK_NORM: cfg.feedback_norm  <= cfg_data[16:0];
        default: ;  // Indexes past the map are ignored.
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/zdf_ctrl.sv
// ----------------------------------------------------------------------------
// zdf_ctrl: filter sequencer
// Steps the shared multiplier through the thirteen products of one sample
// and manages the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module zdf_ctrl
  import zdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_POST = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  op_t              op;
  op_t              op_next;
  logic [STG_W-1:0] idx;
  logic [STG_W-1:0] idx_next;
  logic             out_valid_next;
  logic             last_idx;

  assign last_idx = (idx == STG_W'(NSTAGES - 1));
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    op_next        = op;
    idx_next       = idx;
    out_valid_next = out_valid && !out_ready;
    cmd.load_x     = 1'b0;
    cmd.mul_en     = 1'b0;
    cmd.post_en    = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.op         = op;
    cmd.idx        = idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          op_next    = OP_SCALE;
          idx_next   = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_POST;
      end
      ST_POST: begin
        cmd.post_en = 1'b1;
        state_next  = ST_MUL;
        case (op)
          OP_SCALE: begin
            if (last_idx) begin
              op_next  = OP_FB0;
              idx_next = '0;
            end else begin
              idx_next = idx + 1'b1;
            end
          end
          OP_FB0: op_next = OP_FB1;
          OP_FB1: op_next = OP_FB2;
          OP_FB2: op_next = OP_RES;
          OP_RES: op_next = OP_NORM;
          OP_NORM: begin
            op_next  = OP_STAGE;
            idx_next = '0;
          end
          OP_STAGE: begin
            if (last_idx) begin
              state_next = ST_OUT;
            end else begin
              idx_next = idx + 1'b1;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_SCALE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // The output register is only overwritten once its transaction is done.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while held");

  // Every accepted sample starts with the first state scaling product.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MUL && op == OP_SCALE && idx == '0))
    else $error("sequence did not start at the first product");

  // The last ladder stage hands over to the output step.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && op == OP_STAGE && last_idx) |=> (state == ST_OUT))
    else $error("last stage did not lead to output");

endmodule

`default_nettype wire

// File: hw/rtl/zdf_dp.sv
// ----------------------------------------------------------------------------
// zdf_dp: filter datapath
// One shared signed multiplier with a product register, post-processing
// (rounding, accumulation, saturation), the four integrator states and
// the output sample register.
// ----------------------------------------------------------------------------
`default_nettype none

module zdf_dp
  import zdf_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cfg_t                        cfg,
  input  wire cmd_t                        cmd,
  input  wire logic signed [SAMPLE_W-1:0]  sample_in,
  output logic signed [SAMPLE_W-1:0]       sample_out
);

  logic signed [STATE_W-1:0]  z [NSTAGES];
  logic signed [STATE_W-1:0]  s [NSTAGES];
  logic signed [SAMPLE_W-1:0] x;
  logic signed [PROD_W-1:0]   acc;
  logic signed [PROD_W-1:0]   prod;
  logic signed [STATE_W-1:0]  sum_fb;
  logic signed [STATE_W-1:0]  ks;
  logic signed [STATE_W-1:0]  lp;

  logic signed [STATE_W-1:0]  z_sel;
  logic signed [OPA_W-1:0]    opa;
  logic signed [OPB_W-1:0]    opb;
  logic signed [PROD_W-1:0]   acc_total;
  logic signed [RND_W-1:0]    rp;
  logic signed [RND_W-1:0]    rp_total;
  logic signed [STATE_W-1:0]  rp_sat;
  logic signed [STATE_W-1:0]  sum_next;
  logic signed [STATE_W-1:0]  lp_stage;
  logic signed [STATE_W-1:0]  z_stage;

  assign z_sel = z[cmd.idx];

  // Operand selection for the shared multiplier. Coefficients are unsigned
  // and enter with a zero sign bit.
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      OP_SCALE: begin
        opa = {z_sel[STATE_W-1], z_sel};
        opb = {3'b000, cfg.state_scale};
      end
      OP_FB0: begin
        opa = {s[0][STATE_W-1], s[0]};
        opb = {4'b0000, cfg.gain_cubed};
      end
      OP_FB1: begin
        opa = {s[1][STATE_W-1], s[1]};
        opb = {4'b0000, cfg.gain_squared};
      end
      OP_FB2: begin
        opa = {s[2][STATE_W-1], s[2]};
        opb = {4'b0000, cfg.stage_gain};
      end
      OP_RES: begin
        opa = {sum_fb[STATE_W-1], sum_fb};
        opb = {1'b0, cfg.resonance_gain};
      end
      OP_NORM: begin
        opa = {{(OPA_W-SAMPLE_W){x[SAMPLE_W-1]}}, x} - {ks[STATE_W-1], ks};
        opb = {3'b000, cfg.feedback_norm};
      end
      OP_STAGE: begin
        opa = {lp[STATE_W-1], lp} - {z_sel[STATE_W-1], z_sel};
        opb = {4'b0000, cfg.stage_gain};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Post-processing of the registered product.
  assign acc_total = acc + prod;
  assign rp        = rnd16(prod);
  assign rp_total  = rnd16(acc_total);
  assign rp_sat    = sat32({{(WIDE_W-RND_W){rp[RND_W-1]}}, rp});
  assign sum_next  = sat32({{(WIDE_W-RND_W){rp_total[RND_W-1]}}, rp_total}
                         + {{(WIDE_W-STATE_W){s[3][STATE_W-1]}}, s[3]});
  // One ladder stage: v = rounded product, lp = v + z, z = lp + v.
  assign lp_stage  = sat32({{(WIDE_W-RND_W){rp[RND_W-1]}}, rp}
                         + {{(WIDE_W-STATE_W){z_sel[STATE_W-1]}}, z_sel});
  assign z_stage   = sat32({{(WIDE_W-RND_W){rp[RND_W-1]}}, rp}
                         + {{(WIDE_W-STATE_W){lp_stage[STATE_W-1]}}, lp_stage});

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= sample_in;
    end
    if (cmd.mul_en) begin
      prod <= opa * opb;
    end
    if (cmd.post_en) begin
      case (cmd.op)
        OP_SCALE: s[cmd.idx] <= rp_sat;
        OP_FB0:   acc <= prod;
        OP_FB1:   acc <= acc_total;
        OP_FB2:   sum_fb <= sum_next;
        OP_RES:   ks <= rp_sat;
        OP_NORM:  lp <= rp_sat;
        OP_STAGE: lp <= lp_stage;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      sample_out <= sat24(lp);
    end
  end

  // Integrator states are filter state and are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGES; i++) begin
        z[i] <= '0;
      end
    end else if (cmd.post_en && cmd.op == OP_STAGE) begin
      z[cmd.idx] <= z_stage;
    end
  end

endmodule

`default_nettype wire
